// File: src/asc_pkg.sv
package asc_pkg;

    localparam int N_W      = 16;
    localparam int TIME_W   = 48;
    localparam int DIFF_W   = TIME_W + 1;
    localparam int WANT_W   = 17;
    localparam int SUM_W    = 64;
    localparam int ACC_W    = 80;
    localparam int MUL_A_W  = 32;
    localparam int MUL_B_W  = 19;
    localparam int MUL_P_W  = MUL_A_W + MUL_B_W;
    localparam int STEP_W   = 5;
    localparam int WARM_W   = 5;

    localparam logic [WARM_W-1:0] WARMUP_FRAMES = 5'd20;

    // Reciprocal of 100 scaled by 2^24, rounded down.
    localparam logic [MUL_B_W-1:0] RECIP100 = 19'd167772;
    localparam logic [MUL_B_W-1:0] HUNDRED  = 19'd100;

    typedef logic [3:0] act_t;
    typedef logic [3:0] mul_t;
    typedef logic [2:0] cond_t;

    localparam act_t ACT_NONE    = 4'd0;
    localparam act_t ACT_DIFF    = 4'd1;
    localparam act_t ACT_MAG     = 4'd2;
    localparam act_t ACT_ACC_LO  = 4'd3;
    localparam act_t ACT_ACC_HI  = 4'd4;
    localparam act_t ACT_PROD    = 4'd5;
    localparam act_t ACT_SUMUP   = 4'd6;
    localparam act_t ACT_LATCH_X = 4'd7;
    localparam act_t ACT_LATCH_Q = 4'd8;
    localparam act_t ACT_FIX_LO  = 4'd9;
    localparam act_t ACT_FIX_HI  = 4'd10;
    localparam act_t ACT_OFF     = 4'd11;
    localparam act_t ACT_CLIP    = 4'd12;
    localparam act_t ACT_PASS    = 4'd13;
    localparam act_t ACT_CLEAR   = 4'd14;

    localparam mul_t MUL_HOLD       = 4'd0;
    localparam mul_t MUL_SLO_COEF   = 4'd1;
    localparam mul_t MUL_SHI_COEF   = 4'd2;
    localparam mul_t MUL_SLO_CF     = 4'd3;
    localparam mul_t MUL_SHI_CF     = 4'd4;
    localparam mul_t MUL_DMAG_RATE  = 4'd5;
    localparam mul_t MUL_N_LOPCT    = 4'd6;
    localparam mul_t MUL_N_HIPCT    = 4'd7;
    localparam mul_t MUL_MR_RECIP   = 4'd8;
    localparam mul_t MUL_MR_HUNDRED = 4'd9;

    localparam cond_t COND_NONE    = 3'd0;
    localparam cond_t COND_AUDIO   = 3'd1;
    localparam cond_t COND_NOSYNC  = 3'd2;
    localparam cond_t COND_WARMING = 3'd3;
    localparam cond_t COND_BELOW   = 3'd4;

    localparam logic [STEP_W-1:0] STEP_PASS  = 5'd21;
    localparam logic [STEP_W-1:0] STEP_CLEAR = 5'd22;

    typedef struct packed {
        act_t              act;
        mul_t              mul;
        cond_t             cond;
        logic [STEP_W-1:0] target;
        logic              last;
    } ucode_t;

    typedef struct packed {
        act_t act;
        mul_t mul;
    } ctrl_t;

    typedef struct packed {
        logic is_audio;
        logic nosync;
        logic warming;
        logic below;
    } status_t;

    typedef struct packed {
        logic [1:0]  sync_mode;
        logic        has_video_stream;
        logic        has_audio_stream;
        logic [15:0] avg_coefficient;
        logic [31:0] diff_threshold;
        logic [31:0] nosync_threshold;
        logic [18:0] sample_rate;
        logic [6:0]  correction_percent;
    } cfg_t;

    typedef struct packed {
        logic        external_time_valid;
        logic [47:0] external_time;
        logic        video_time_valid;
        logic [47:0] video_time;
        logic        audio_time_valid;
        logic [47:0] audio_time;
        logic [15:0] frame_samples;
    } item_t;

    function automatic ucode_t uword(act_t act, mul_t mul, cond_t cond,
                                     logic [STEP_W-1:0] target, logic last);
        ucode_t w;
        w.act    = act;
        w.mul    = mul;
        w.cond   = cond;
        w.target = target;
        w.last   = last;
        return w;
    endfunction

    function automatic ucode_t ucode_rom(logic [STEP_W-1:0] step);
        ucode_t w;
        unique case (step)
            5'd0:  w = uword(ACT_DIFF,    MUL_HOLD,       COND_AUDIO,   STEP_PASS,  1'b0);
            5'd1:  w = uword(ACT_MAG,     MUL_HOLD,       COND_NONE,    5'd0,       1'b0);
            5'd2:  w = uword(ACT_NONE,    MUL_SLO_COEF,   COND_NOSYNC,  STEP_CLEAR, 1'b0);
            5'd3:  w = uword(ACT_ACC_LO,  MUL_SHI_COEF,   COND_NONE,    5'd0,       1'b0);
            5'd4:  w = uword(ACT_ACC_HI,  MUL_HOLD,       COND_NONE,    5'd0,       1'b0);
            5'd5:  w = uword(ACT_PROD,    MUL_HOLD,       COND_NONE,    5'd0,       1'b0);
            5'd6:  w = uword(ACT_SUMUP,   MUL_HOLD,       COND_WARMING, STEP_PASS,  1'b0);
            5'd7:  w = uword(ACT_MAG,     MUL_HOLD,       COND_NONE,    5'd0,       1'b0);
            5'd8:  w = uword(ACT_NONE,    MUL_SLO_CF,     COND_NONE,    5'd0,       1'b0);
            5'd9:  w = uword(ACT_ACC_LO,  MUL_SHI_CF,     COND_NONE,    5'd0,       1'b0);
            5'd10: w = uword(ACT_ACC_HI,  MUL_HOLD,       COND_NONE,    5'd0,       1'b0);
            5'd11: w = uword(ACT_NONE,    MUL_DMAG_RATE,  COND_BELOW,   STEP_PASS,  1'b0);
            5'd12: w = uword(ACT_ACC_LO,  MUL_N_LOPCT,    COND_NONE,    5'd0,       1'b0);
            5'd13: w = uword(ACT_LATCH_X, MUL_MR_RECIP,   COND_NONE,    5'd0,       1'b0);
            5'd14: w = uword(ACT_LATCH_Q, MUL_MR_HUNDRED, COND_NONE,    5'd0,       1'b0);
            5'd15: w = uword(ACT_FIX_LO,  MUL_N_HIPCT,    COND_NONE,    5'd0,       1'b0);
            5'd16: w = uword(ACT_LATCH_X, MUL_MR_RECIP,   COND_NONE,    5'd0,       1'b0);
            5'd17: w = uword(ACT_LATCH_Q, MUL_MR_HUNDRED, COND_NONE,    5'd0,       1'b0);
            5'd18: w = uword(ACT_FIX_HI,  MUL_HOLD,       COND_NONE,    5'd0,       1'b0);
            5'd19: w = uword(ACT_OFF,     MUL_HOLD,       COND_NONE,    5'd0,       1'b0);
            5'd20: w = uword(ACT_CLIP,    MUL_HOLD,       COND_NONE,    5'd0,       1'b1);
            5'd21: w = uword(ACT_PASS,    MUL_HOLD,       COND_NONE,    5'd0,       1'b1);
            5'd22: w = uword(ACT_CLEAR,   MUL_HOLD,       COND_NONE,    5'd0,       1'b1);
            default: w = uword(ACT_PASS,  MUL_HOLD,       COND_NONE,    5'd0,       1'b1);
        endcase
        return w;
    endfunction

endpackage

// File: src/asc_sequencer.sv
module asc_sequencer (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic             out_free,
    input  asc_pkg::status_t status,
    output asc_pkg::ctrl_t   ctrl,
    output logic             busy,
    output logic             done
);

    logic                       busy_reg;
    logic                       busy_next;
    logic [asc_pkg::STEP_W-1:0] step_reg;
    logic [asc_pkg::STEP_W-1:0] step_next;
    asc_pkg::ucode_t            word;
    logic                       taken;
    logic                       run;

    assign word = asc_pkg::ucode_rom(step_reg);

    // The closing step writes the output register, so it waits for a free slot.
    assign run = busy_reg && !(word.last && !out_free);

    always_comb
    begin
        unique case (word.cond)
            asc_pkg::COND_AUDIO:   taken = status.is_audio;
            asc_pkg::COND_NOSYNC:  taken = status.nosync;
            asc_pkg::COND_WARMING: taken = status.warming;
            asc_pkg::COND_BELOW:   taken = status.below;
            default:               taken = 1'b0;
        endcase
    end

    always_comb
    begin
        busy_next = busy_reg;
        step_next = step_reg;
        if (start)
        begin
            busy_next = 1'b1;
            step_next = '0;
        end
        else if (run)
        begin
            if (word.last)
            begin
                busy_next = 1'b0;
            end
            else if (taken)
            begin
                step_next = word.target;
            end
            else
            begin
                step_next = step_reg + 5'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            step_reg <= step_next;
        end
    end

    assign ctrl.act = run ? word.act : asc_pkg::ACT_NONE;
    assign ctrl.mul = run ? word.mul : asc_pkg::MUL_HOLD;
    assign busy     = busy_reg;
    assign done     = run && word.last;

endmodule

// File: src/asc_datapath.sv
module asc_datapath (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        load,
    input  asc_pkg::item_t              item,
    input  asc_pkg::cfg_t               cfg,
    input  asc_pkg::ctrl_t              ctrl,
    output asc_pkg::status_t            status,
    output logic [asc_pkg::WANT_W-1:0]  wanted_samples,
    output logic                        corrected
);

    localparam logic [1:0] SYNC_AUDIO = 2'd0;
    localparam logic [1:0] SYNC_VIDEO = 2'd1;
    localparam logic [1:0] KIND_AUDIO = 2'd0;
    localparam logic [1:0] KIND_VIDEO = 2'd1;
    localparam logic [1:0] KIND_EXT   = 2'd2;

    asc_pkg::item_t                   in_reg;
    logic signed [asc_pkg::DIFF_W-1:0] diff_reg;
    logic [asc_pkg::DIFF_W-1:0]       dmag_reg;
    logic [asc_pkg::SUM_W-1:0]        smag_reg;
    logic [asc_pkg::MUL_P_W-1:0]      mul_reg;
    logic [asc_pkg::ACC_W-1:0]        acc_reg;
    logic [asc_pkg::SUM_W-1:0]        prod_reg;
    logic [asc_pkg::SUM_W-1:0]        sum_reg;
    logic [asc_pkg::SUM_W-1:0]        sum_next;
    logic [asc_pkg::WARM_W-1:0]       warm_reg;
    logic [asc_pkg::WARM_W-1:0]       warm_next;
    logic [23:0]                      x_reg;
    logic [16:0]                      q_reg;
    logic [16:0]                      lo_reg;
    logic [16:0]                      hi_reg;
    logic signed [37:0]               w_reg;
    logic [asc_pkg::WANT_W-1:0]       wanted_reg;
    logic                             corrected_reg;

    logic [1:0]                       kind;
    logic                             m_ok;
    logic signed [asc_pkg::DIFF_W-1:0] a_ext;
    logic signed [asc_pkg::DIFF_W-1:0] m_ext;
    logic [asc_pkg::MUL_A_W-1:0]      mul_a;
    logic [asc_pkg::MUL_B_W-1:0]      mul_b;
    logic [16:0]                      cf;
    logic [6:0]                       pct;
    logic [63:0]                      pm;
    logic [64:0]                      sum_wide;
    logic [23:0]                      rem;
    logic [16:0]                      q_fixed;
    logic signed [37:0]               lo_s;
    logic signed [37:0]               hi_s;
    logic [37:0]                      offm;

    always_comb
    begin
        unique case (cfg.sync_mode)
            SYNC_VIDEO: kind = cfg.has_video_stream ? KIND_VIDEO : KIND_AUDIO;
            SYNC_AUDIO: kind = cfg.has_audio_stream ? KIND_AUDIO : KIND_EXT;
            default:    kind = KIND_EXT;
        endcase
    end

    assign a_ext = signed'({in_reg.audio_time[47], in_reg.audio_time});
    assign m_ext = (kind == KIND_VIDEO) ?
                   signed'({in_reg.video_time[47], in_reg.video_time}) :
                   signed'({in_reg.external_time[47], in_reg.external_time});
    assign m_ok  = (kind == KIND_VIDEO) ? in_reg.video_time_valid :
                   in_reg.external_time_valid;

    assign cf  = 17'h10000 - {1'b0, cfg.avg_coefficient};
    assign pct = (cfg.correction_percent > 7'd100) ? 7'd100 : cfg.correction_percent;
    assign pm  = acc_reg[79:16];

    assign status.is_audio = (kind == KIND_AUDIO);
    assign status.nosync   = !(in_reg.audio_time_valid && m_ok &&
                               (dmag_reg < {17'd0, cfg.nosync_threshold}));
    assign status.warming  = (warm_reg < asc_pkg::WARMUP_FRAMES);
    assign status.below    = (pm < {32'd0, cfg.diff_threshold});

    always_comb
    begin
        unique case (ctrl.mul)
            asc_pkg::MUL_SLO_COEF:
            begin
                mul_a = smag_reg[31:0];
                mul_b = {3'd0, cfg.avg_coefficient};
            end
            asc_pkg::MUL_SHI_COEF:
            begin
                mul_a = smag_reg[63:32];
                mul_b = {3'd0, cfg.avg_coefficient};
            end
            asc_pkg::MUL_SLO_CF:
            begin
                mul_a = smag_reg[31:0];
                mul_b = {2'd0, cf};
            end
            asc_pkg::MUL_SHI_CF:
            begin
                mul_a = smag_reg[63:32];
                mul_b = {2'd0, cf};
            end
            asc_pkg::MUL_DMAG_RATE:
            begin
                mul_a = dmag_reg[31:0];
                mul_b = cfg.sample_rate;
            end
            asc_pkg::MUL_N_LOPCT:
            begin
                mul_a = {16'd0, in_reg.frame_samples};
                mul_b = {12'd0, 7'(7'd100 - pct)};
            end
            asc_pkg::MUL_N_HIPCT:
            begin
                mul_a = {16'd0, in_reg.frame_samples};
                mul_b = {11'd0, 8'(8'd100 + {1'b0, pct})};
            end
            asc_pkg::MUL_MR_RECIP:
            begin
                mul_a = {8'd0, mul_reg[23:0]};
                mul_b = asc_pkg::RECIP100;
            end
            asc_pkg::MUL_MR_HUNDRED:
            begin
                mul_a = {15'd0, mul_reg[40:24]};
                mul_b = asc_pkg::HUNDRED;
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign sum_wide = {prod_reg[63], prod_reg} + {{16{diff_reg[48]}}, diff_reg};
    assign rem      = x_reg - mul_reg[23:0];
    assign q_fixed  = (rem >= 24'd100) ? 17'(q_reg + 17'd1) : q_reg;
    assign offm     = {3'd0, acc_reg[50:16]};
    assign lo_s     = signed'({21'd0, lo_reg});
    assign hi_s     = signed'({21'd0, hi_reg});

    always_comb
    begin
        sum_next  = sum_reg;
        warm_next = warm_reg;
        unique case (ctrl.act)
            asc_pkg::ACT_SUMUP:
            begin
                unique case (sum_wide[64:63])
                    2'b01:   sum_next = 64'h7FFF_FFFF_FFFF_FFFF;
                    2'b10:   sum_next = 64'h8000_0000_0000_0000;
                    default: sum_next = sum_wide[63:0];
                endcase
                if (warm_reg < asc_pkg::WARMUP_FRAMES)
                begin
                    warm_next = warm_reg + 5'd1;
                end
            end
            asc_pkg::ACT_CLEAR:
            begin
                sum_next  = '0;
                warm_next = '0;
            end
            default:
            begin
                sum_next  = sum_reg;
                warm_next = warm_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg  <= '0;
            warm_reg <= '0;
        end
        else
        begin
            sum_reg  <= sum_next;
            warm_reg <= warm_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            in_reg <= item;
        end
        if (ctrl.mul != asc_pkg::MUL_HOLD)
        begin
            mul_reg <= mul_a * mul_b;
        end
        unique case (ctrl.act)
            asc_pkg::ACT_DIFF:
            begin
                diff_reg <= a_ext - m_ext;
            end
            asc_pkg::ACT_MAG:
            begin
                dmag_reg <= diff_reg[48] ? 49'(-diff_reg) : diff_reg;
                smag_reg <= sum_reg[63] ? 64'(64'd0 - sum_reg) : sum_reg;
            end
            asc_pkg::ACT_ACC_LO:
            begin
                acc_reg <= {29'd0, mul_reg};
            end
            asc_pkg::ACT_ACC_HI:
            begin
                acc_reg <= acc_reg + {mul_reg[47:0], 32'd0};
            end
            asc_pkg::ACT_PROD:
            begin
                prod_reg <= sum_reg[63] ? 64'(64'd0 - pm) : pm;
            end
            asc_pkg::ACT_LATCH_X:
            begin
                x_reg <= mul_reg[23:0];
            end
            asc_pkg::ACT_LATCH_Q:
            begin
                q_reg <= mul_reg[40:24];
            end
            asc_pkg::ACT_FIX_LO:
            begin
                lo_reg <= q_fixed;
            end
            asc_pkg::ACT_FIX_HI:
            begin
                hi_reg <= q_fixed;
            end
            asc_pkg::ACT_OFF:
            begin
                w_reg <= diff_reg[48] ?
                         signed'(38'({22'd0, in_reg.frame_samples} - offm)) :
                         signed'(38'({22'd0, in_reg.frame_samples} + offm));
            end
            asc_pkg::ACT_CLIP:
            begin
                if (w_reg < lo_s)
                begin
                    wanted_reg <= lo_reg;
                end
                else if (w_reg > hi_s)
                begin
                    wanted_reg <= hi_reg;
                end
                else
                begin
                    wanted_reg <= w_reg[16:0];
                end
                corrected_reg <= 1'b1;
            end
            asc_pkg::ACT_PASS,
            asc_pkg::ACT_CLEAR:
            begin
                wanted_reg    <= {1'b0, in_reg.frame_samples};
                corrected_reg <= 1'b0;
            end
            default:
            begin
            end
        endcase
    end

    assign wanted_samples = wanted_reg;
    assign corrected      = corrected_reg;

endmodule

// File: src/audio_sync_sample_correction.sv
// Audio drift correction for A/V sync: for each decoded audio frame it returns the sample
// count to produce and a flag telling whether a correction was applied. When a master other
// than audio is selected it tracks an exponentially weighted audio-minus-master difference
// and, after the warm-up frames and unless that average is below the threshold, stretches
// or shrinks the count by difference times sample rate, clipped to the configured
// percentage. A microprogram steps one shared 32x19 multiplier through the work, with the
// input not ready meanwhile, and shortens the path with audio master, when averaging resets,
// during warm-up and below the threshold. The result waits in the output register; the next
// frame is accepted meanwhile and stalls only at its last step while that register is full.
module audio_sync_sample_correction (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [4:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready,
    input  logic         s_tvalid,
    output logic         s_tready,
    // frame_samples, audio_time, audio_time_valid, video_time, video_time_valid,
    // external_time, external_time_valid, zero fill
    input  logic [167:0] s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // wanted_samples, corrected, zero fill
    output logic [23:0]  m_tdata
);

    localparam logic [2:0] REG_SYNC_MODE   = 3'd0;
    localparam logic [2:0] REG_HAS_VIDEO   = 3'd1;
    localparam logic [2:0] REG_HAS_AUDIO   = 3'd2;
    localparam logic [2:0] REG_COEF        = 3'd3;
    localparam logic [2:0] REG_DIFF_THR    = 3'd4;
    localparam logic [2:0] REG_NOSYNC_THR  = 3'd5;
    localparam logic [2:0] REG_SAMPLE_RATE = 3'd6;
    localparam logic [2:0] REG_PERCENT     = 3'd7;

    asc_pkg::cfg_t                  cfg_reg;
    logic                           m_tvalid_reg;
    logic                           m_tvalid_next;
    logic                           cfg_wr;
    logic [2:0]                     reg_idx;
    logic                           start;
    logic                           busy;
    logic                           done;
    logic                           out_free;
    asc_pkg::ctrl_t                 ctrl;
    asc_pkg::status_t               status;
    asc_pkg::item_t                 item;
    logic [asc_pkg::WANT_W-1:0]     wanted_samples;
    logic                           corrected;

    assign pready  = 1'b1;
    assign reg_idx = paddr[4:2];
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.sync_mode          <= 2'd0;
            cfg_reg.has_video_stream   <= 1'b0;
            cfg_reg.has_audio_stream   <= 1'b1;
            cfg_reg.avg_coefficient    <= 16'd52057;
            cfg_reg.diff_threshold     <= 32'd2621;
            cfg_reg.nosync_threshold   <= 32'd655360;
            cfg_reg.sample_rate        <= 19'd48000;
            cfg_reg.correction_percent <= 7'd10;
        end
        else if (cfg_wr)
        begin
            unique case (reg_idx)
                REG_SYNC_MODE:   cfg_reg.sync_mode          <= pwdata[1:0];
                REG_HAS_VIDEO:   cfg_reg.has_video_stream   <= pwdata[0];
                REG_HAS_AUDIO:   cfg_reg.has_audio_stream   <= pwdata[0];
                REG_COEF:        cfg_reg.avg_coefficient    <= pwdata[15:0];
                REG_DIFF_THR:    cfg_reg.diff_threshold     <= pwdata;
                REG_NOSYNC_THR:  cfg_reg.nosync_threshold   <= pwdata;
                REG_SAMPLE_RATE: cfg_reg.sample_rate        <= pwdata[18:0];
                REG_PERCENT:     cfg_reg.correction_percent <= pwdata[6:0];
                default:         cfg_reg.sync_mode          <= cfg_reg.sync_mode;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            REG_SYNC_MODE:   prdata = {30'd0, cfg_reg.sync_mode};
            REG_HAS_VIDEO:   prdata = {31'd0, cfg_reg.has_video_stream};
            REG_HAS_AUDIO:   prdata = {31'd0, cfg_reg.has_audio_stream};
            REG_COEF:        prdata = {16'd0, cfg_reg.avg_coefficient};
            REG_DIFF_THR:    prdata = cfg_reg.diff_threshold;
            REG_NOSYNC_THR:  prdata = cfg_reg.nosync_threshold;
            REG_SAMPLE_RATE: prdata = {13'd0, cfg_reg.sample_rate};
            REG_PERCENT:     prdata = {25'd0, cfg_reg.correction_percent};
            default:         prdata = '0;
        endcase
    end

    assign item.frame_samples       = s_tdata[15:0];
    assign item.audio_time          = s_tdata[63:16];
    assign item.audio_time_valid    = s_tdata[64];
    assign item.video_time          = s_tdata[112:65];
    assign item.video_time_valid    = s_tdata[113];
    assign item.external_time       = s_tdata[161:114];
    assign item.external_time_valid = s_tdata[162];

    assign s_tready = !busy;
    assign start    = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;

    always_comb
    begin
        m_tvalid_next = m_tvalid_reg;
        if (done)
        begin
            m_tvalid_next = 1'b1;
        end
        else if (m_tready)
        begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    asc_sequencer u_seq (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .out_free (out_free),
        .status   (status),
        .ctrl     (ctrl),
        .busy     (busy),
        .done     (done)
    );

    asc_datapath u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .load           (start),
        .item           (item),
        .cfg            (cfg_reg),
        .ctrl           (ctrl),
        .status         (status),
        .wanted_samples (wanted_samples),
        .corrected      (corrected)
    );

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {6'd0, corrected, wanted_samples};

endmodule

// File: tb/sv/asc_tb_pkg.sv
`timescale 1ns / 1ps
package asc_tb_pkg;

    localparam int REG_SYNC_MODE          = 0;
    localparam int REG_HAS_VIDEO_STREAM   = 1;
    localparam int REG_HAS_AUDIO_STREAM   = 2;
    localparam int REG_AVG_COEFFICIENT    = 3;
    localparam int REG_DIFF_THRESHOLD     = 4;
    localparam int REG_NOSYNC_THRESHOLD   = 5;
    localparam int REG_SAMPLE_RATE        = 6;
    localparam int REG_CORRECTION_PERCENT = 7;

    localparam logic [1:0] SYNC_AUDIO    = 2'd0;
    localparam logic [1:0] SYNC_VIDEO    = 2'd1;
    localparam logic [1:0] SYNC_EXTERNAL = 2'd2;
    localparam logic [1:0] SYNC_UNUSED   = 2'd3;

    typedef enum logic [1:0] {
        MASTER_AUDIO,
        MASTER_VIDEO,
        MASTER_EXTERNAL
    } master_e;

    typedef struct packed {
        logic        corrected;
        logic [16:0] wanted;
    } frame_result_t;

endpackage

// File: tb/sv/asc_checker.sv
`timescale 1ns / 1ps
module asc_checker
    import asc_pkg::*;
    import asc_tb_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [4:0]   paddr,
    input  logic [31:0]  pwdata,
    input  logic         pready,
    input  logic         s_tvalid,
    input  logic         s_tready,
    input  logic [167:0] s_tdata,
    input  logic         m_tvalid,
    input  logic         m_tready,
    input  logic [23:0]  m_tdata,
    output int           errors,
    output int           outstanding
);

    localparam longint SUM_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
    localparam longint SUM_MIN = 64'sh8000_0000_0000_0000;

    cfg_t          settings;
    longint        drift_sum;
    logic [4:0]    warm_frames;
    frame_result_t pending_results[$];

    initial errors = 0;

    task automatic report_mismatch(input string what, input longint expv, input longint gotv);
        $display("%0t ns: %s: expected %0d, got %0d", $time, what, expv, gotv);
        errors++;
    endtask

    function automatic longint unsigned magnitude(input longint v);
        longint unsigned u;
        u = v;
        return (v < 0) ? (64'd0 - u) : u;
    endfunction

    // (mag * f) / 2^16 truncated, split so that nothing overflows 64 bits.
    function automatic longint unsigned scale_q16(input longint unsigned mag,
                                                  input longint unsigned f);
        return (mag >> 16) * f + (((mag & 64'hFFFF) * f) >> 16);
    endfunction

    function automatic frame_result_t drift_correct(input item_t fr);
        frame_result_t       res;
        master_e             master;
        longint              a_t;
        longint              m_t;
        longint              diff;
        longint              prod;
        longint              w;
        longint              lo;
        longint              hi;
        longint unsigned     dmag;
        longint unsigned     pm;
        longint unsigned     avg;
        longint unsigned     offm;
        longint unsigned     pct;
        logic                m_ok;
        logic signed [64:0]  wide;

        case (settings.sync_mode)
            SYNC_VIDEO: master = settings.has_video_stream ? MASTER_VIDEO : MASTER_AUDIO;
            SYNC_AUDIO: master = settings.has_audio_stream ? MASTER_AUDIO : MASTER_EXTERNAL;
            default:    master = MASTER_EXTERNAL;
        endcase

        res.wanted    = {1'b0, fr.frame_samples};
        res.corrected = 1'b0;

        if (master != MASTER_AUDIO)
        begin
            a_t = $signed(fr.audio_time);
            if (master == MASTER_VIDEO)
            begin
                m_t  = $signed(fr.video_time);
                m_ok = fr.video_time_valid;
            end
            else
            begin
                m_t  = $signed(fr.external_time);
                m_ok = fr.external_time_valid;
            end
            diff = a_t - m_t;
            dmag = magnitude(diff);

            if (fr.audio_time_valid && m_ok && dmag < settings.nosync_threshold)
            begin
                pm   = scale_q16(magnitude(drift_sum), settings.avg_coefficient);
                prod = (drift_sum < 0) ? -longint'(pm) : longint'(pm);
                wide = prod;
                wide = wide + diff;
                if (wide > SUM_MAX)
                    drift_sum = SUM_MAX;
                else if (wide < SUM_MIN)
                    drift_sum = SUM_MIN;
                else
                    drift_sum = wide[63:0];

                if (warm_frames < WARMUP_FRAMES)
                begin
                    warm_frames = warm_frames + 5'd1;
                end
                else
                begin
                    avg = scale_q16(magnitude(drift_sum), 64'd65536 - settings.avg_coefficient);
                    if (avg >= settings.diff_threshold)
                    begin
                        offm = (dmag * settings.sample_rate) >> 16;
                        w    = fr.frame_samples;
                        w    = (diff < 0) ? w - longint'(offm) : w + longint'(offm);
                        pct  = (settings.correction_percent > 7'd100) ? 64'd100
                                                                     : settings.correction_percent;
                        lo   = (fr.frame_samples * (64'd100 - pct)) / 64'd100;
                        hi   = (fr.frame_samples * (64'd100 + pct)) / 64'd100;
                        if (w < lo)
                            w = lo;
                        if (w > hi)
                            w = hi;
                        res.wanted    = w[16:0];
                        res.corrected = 1'b1;
                    end
                end
            end
            else
            begin
                drift_sum   = 0;
                warm_frames = '0;
            end
        end
        return res;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : monitor
        frame_result_t want;
        item_t         fr;
        if (!rst_n)
        begin
            settings.sync_mode          = SYNC_AUDIO;
            settings.has_video_stream   = 1'b0;
            settings.has_audio_stream   = 1'b1;
            settings.avg_coefficient    = 16'd52057;
            settings.diff_threshold     = 32'd2621;
            settings.nosync_threshold   = 32'd655360;
            settings.sample_rate        = 19'd48000;
            settings.correction_percent = 7'd10;
            drift_sum   = 0;
            warm_frames = '0;
            pending_results.delete();
            outstanding <= 0;
        end
        else
        begin
            if (psel && penable && pwrite && pready)
            begin
                case (paddr[4:2])
                    REG_SYNC_MODE:          settings.sync_mode          = pwdata[1:0];
                    REG_HAS_VIDEO_STREAM:   settings.has_video_stream   = pwdata[0];
                    REG_HAS_AUDIO_STREAM:   settings.has_audio_stream   = pwdata[0];
                    REG_AVG_COEFFICIENT:    settings.avg_coefficient    = pwdata[15:0];
                    REG_DIFF_THRESHOLD:     settings.diff_threshold     = pwdata;
                    REG_NOSYNC_THRESHOLD:   settings.nosync_threshold   = pwdata;
                    REG_SAMPLE_RATE:        settings.sample_rate        = pwdata[18:0];
                    REG_CORRECTION_PERCENT: settings.correction_percent = pwdata[6:0];
                    default: ;
                endcase
            end

            if (m_tvalid && m_tready)
            begin
                if (pending_results.size() == 0)
                begin
                    report_mismatch("output word with nothing expected", 0, m_tdata[16:0]);
                end
                else
                begin
                    want = pending_results.pop_front();
                    if (m_tdata[16:0] != want.wanted)
                        report_mismatch("wanted_samples", want.wanted, m_tdata[16:0]);
                    if (m_tdata[17] != want.corrected)
                        report_mismatch("corrected", want.corrected, m_tdata[17]);
                end
            end

            if (s_tvalid && s_tready)
            begin
                fr = s_tdata[$bits(item_t)-1:0];
                pending_results.push_back(drift_correct(fr));
            end

            outstanding <= pending_results.size();
        end
    end

endmodule

// File: tb/sv/tb_top.sv
`timescale 1ns / 1ps
module tb_top;
    import asc_pkg::*;
    import asc_tb_pkg::*;

    logic         clk      = 1'b0;
    logic         rst_n    = 1'b0;
    logic         psel     = 1'b0;
    logic         penable  = 1'b0;
    logic         pwrite   = 1'b0;
    logic [4:0]   paddr    = '0;
    logic [31:0]  pwdata   = '0;
    logic [31:0]  prdata;
    logic         pready;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [167:0] s_tdata  = '0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [23:0]  m_tdata;

    int           errors;
    int           outstanding;
    int           send_idle_pct  = 0;
    int           recv_stall_pct = 0;
    logic         long_hold      = 1'b0;
    int           hold_cycles    = 0;
    logic [31:0]  cur_nosync     = 32'd655360;

    always #5 clk = ~clk;

    audio_sync_sample_correction u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    asc_checker u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .pready      (pready),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .errors      (errors),
        .outstanding (outstanding)
    );

    // The long hold-off keeps output words back until the block fills up and stalls its input.
    always @(posedge clk)
    begin
        if (long_hold && hold_cycles < 400)
        begin
            m_tready    <= 1'b0;
            hold_cycles <= hold_cycles + 1;
        end
        else
        begin
            m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    task automatic reg_write(input int idx, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= 5'(idx * 4);
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
    endtask

    task automatic write_settings(input logic [1:0] mode, input logic video, input logic audio,
                                  input logic [15:0] coef, input logic [31:0] thr,
                                  input logic [31:0] nosync, input logic [18:0] rate,
                                  input logic [6:0] pct);
        reg_write(REG_SYNC_MODE, 32'(mode));
        reg_write(REG_HAS_VIDEO_STREAM, 32'(video));
        reg_write(REG_HAS_AUDIO_STREAM, 32'(audio));
        reg_write(REG_AVG_COEFFICIENT, 32'(coef));
        reg_write(REG_DIFF_THRESHOLD, thr);
        reg_write(REG_NOSYNC_THRESHOLD, nosync);
        reg_write(REG_SAMPLE_RATE, 32'(rate));
        reg_write(REG_CORRECTION_PERCENT, 32'(pct));
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
        cur_nosync = nosync;
    endtask

    task automatic send_frame(input item_t fr);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {5'b0, fr};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
    endtask

    task automatic drain_results();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    function automatic item_t frame_of(input logic [15:0] n, input logic [47:0] a,
                                       input logic av, input logic [47:0] v, input logic vv);
        item_t fr;
        fr.frame_samples       = n;
        fr.audio_time          = a;
        fr.audio_time_valid    = av;
        fr.video_time          = v;
        fr.video_time_valid    = vv;
        fr.external_time       = v;
        fr.external_time_valid = vv;
        return fr;
    endfunction

    initial
    begin
        #5_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial
    begin : stimulus
        int          ph;
        int          k;
        int          shape;
        int          neg_pct;
        logic [47:0] t0;
        logic [63:0] base;
        logic [63:0] mag;
        item_t       fr;

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        write_settings(SYNC_VIDEO, 1'b1, 1'b1, 16'd52057, 32'd2621, 32'd655360,
                       19'd48000, 7'd10);
        t0 = 48'h0000_1234_0000;
        send_frame(frame_of(16'hFFFF, 48'h7FFF_FFFF_FFFF, 1'b1, 48'h8000_0000_0000, 1'b1));
        send_frame(frame_of(16'd0, 48'd0, 1'b0, 48'd0, 1'b1));
        send_frame(frame_of(16'd1, 48'd0, 1'b1, 48'd0, 1'b0));
        for (k = 0; k < 20; k++)
            send_frame(frame_of(16'd1000, t0 + 48'd16384, 1'b1, t0, 1'b1));
        send_frame(frame_of(16'd1000, t0 + 48'd32768, 1'b1, t0, 1'b1));
        send_frame(frame_of(16'd1000, t0 - 48'd32768, 1'b1, t0, 1'b1));
        send_frame(frame_of(16'hFFFF, t0 + 48'd589824, 1'b1, t0, 1'b1));
        send_frame(frame_of(16'hFFFF, t0 + 48'd100, 1'b1, t0, 1'b1));
        drain_results();

        for (ph = 0; ph < 10; ph++)
        begin
            case (ph)
                0: write_settings(SYNC_VIDEO, 1'b1, 1'b1, 16'd52057, 32'd2621, 32'd655360,
                                  19'd48000, 7'd10);
                1: write_settings(SYNC_AUDIO, 1'b1, 1'b0, 16'd0, 32'd0, 32'hFFFF_FFFF,
                                  19'h7FFFF, 7'd99);
                2: write_settings(SYNC_UNUSED, 1'b0, 1'b1, 16'hFFFF, 32'd0, 32'h0010_0000,
                                  19'd0, 7'd127);
                3: write_settings(SYNC_EXTERNAL, 1'b0, 1'b0, 16'hFFFF, 32'hFFFF_FFFF,
                                  32'hFFFF_FFFF, 19'd1, 7'd0);
                4: write_settings(SYNC_VIDEO, 1'b0, 1'b1, 16'($urandom), 32'($urandom),
                                  32'd0, 19'($urandom), 7'($urandom));
                5: write_settings(SYNC_AUDIO, 1'b0, 1'b1, 16'd40000, 32'd100, 32'd300000,
                                  19'd44100, 7'd5);
                default: write_settings(2'($urandom_range(0, 3)), 1'($urandom),
                                        1'($urandom), 16'($urandom),
                                        $urandom >> $urandom_range(0, 31),
                                        $urandom >> $urandom_range(0, 12),
                                        19'($urandom_range(0, 19'h7FFFF)),
                                        7'($urandom_range(0, 127)));
            endcase

            case (ph % 4)
                0:
                begin
                    send_idle_pct = 0;
                    recv_stall_pct <= 0;
                end
                1:
                begin
                    send_idle_pct = 87;
                    recv_stall_pct <= 0;
                end
                2:
                begin
                    send_idle_pct = 0;
                    recv_stall_pct <= 87;
                end
                default:
                begin
                    send_idle_pct = 26;
                    recv_stall_pct <= 26;
                end
            endcase
            if (ph == 0)
                long_hold <= 1'b1;

            case (ph % 3)
                0: neg_pct = 10;
                1: neg_pct = 90;
                default: neg_pct = 50;
            endcase

            for (k = 0; k < 110; k++)
            begin
                shape                  = $urandom_range(0, 99);
                base                   = {$urandom, $urandom};
                fr.frame_samples       = 16'($urandom);
                fr.audio_time          = base[47:0];
                fr.audio_time_valid    = 1'b1;
                fr.video_time_valid    = 1'b1;
                fr.external_time_valid = 1'b1;
                if (cur_nosync == 32'd0)
                    mag = 64'd0;
                else
                    mag = $urandom_range(0, cur_nosync - 32'd1);
                if (shape < 45)
                    mag = mag >> $urandom_range(0, 24);
                else if (shape >= 94)
                    mag = 64'(cur_nosync) + 64'($urandom_range(0, 4095));
                if ($urandom_range(0, 99) < neg_pct)
                    mag = 64'd0 - mag;
                fr.video_time    = 48'(base - mag);
                fr.external_time = 48'(base - (mag ^ 64'($urandom_range(0, 255))));
                if (shape >= 88 && shape < 94)
                begin
                    case ($urandom_range(0, 2))
                        0: fr.audio_time_valid = 1'b0;
                        1: fr.video_time_valid = 1'b0;
                        default: fr.external_time_valid = 1'b0;
                    endcase
                end
                if (shape < 6)
                begin
                    fr.video_time          = 48'({$urandom, $urandom});
                    fr.external_time       = 48'({$urandom, $urandom});
                    fr.audio_time_valid    = 1'($urandom);
                    fr.video_time_valid    = 1'($urandom);
                    fr.external_time_valid = 1'($urandom);
                end
                send_frame(fr);
            end
            drain_results();
        end

        repeat (30) @(posedge clk);
        if (errors == 0 && outstanding == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

// File: filelist.f
src/asc_pkg.sv
src/asc_sequencer.sv
src/asc_datapath.sv
src/audio_sync_sample_correction.sv
tb/sv/asc_tb_pkg.sv
tb/sv/asc_checker.sv
tb/sv/tb_top.sv
